[hdl/nearest_landmark_association_macros.svh]
// Assertion macros for the nearest landmark association block.
// Used by the RTL files that check their own logic; needs clk and rst_n in scope.
`ifndef NEAREST_LANDMARK_ASSOCIATION_MACROS_SVH
`define NEAREST_LANDMARK_ASSOCIATION_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define NLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that implies a consequence in the next cycle.
`define NLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/nla_pkg.sv]
// Package for the nearest landmark association block.
// Holds shared constants, request codes, the controller state type and the
// command and status structs; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package nla_pkg;

  localparam int MAX_LANDMARKS_DEF = 64;
  localparam int COORD_BITS_DEF    = 24;

  localparam int FUNC_W = 2;
  localparam int ID_W   = 15;
  localparam int OUT_W  = 16;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ASSOC  = 2'd2;

  localparam logic [OUT_W-1:0] NO_MATCH = 16'hFFFF;

  // Cut-off distance of 99999 metres in Q.8 raw units and its square.
  localparam int                 LIM_W      = 25;
  localparam logic [LIM_W-1:0]   CUTOFF_RAW = 25'(99999 * 256);
  localparam int                 BEST_W     = 2 * LIM_W + 1;
  localparam logic [BEST_W-1:0]  CUTOFF_SQ  = BEST_W'(CUTOFF_RAW) * BEST_W'(CUTOFF_RAW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic init;
    logic clear;
    logic append;
    logic issue;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
  } status_t;

endpackage

`default_nettype wire

[hdl/nearest_landmark_association.sv]
// Top level of the nearest landmark association block.
// Joins the controller (nla_ctrl) and the datapath (nla_datapath); uses nla_pkg.
//
//   channel   ports                                          request marked by
//   input     in_func, in_pos_x, in_pos_y, in_landmark_id    start high, busy low
//   result    out_matched_id                                 out_valid, one cycle
//
// A clear or an append leaves busy low.
// An associate request keeps busy high through the one-entry-per-cycle scan of the
// table through the single memory read port and the drain of the distance pipeline
// (memory read, magnitude, square and running-minimum registers).
// out_valid is high in the first cycle that busy is low again. Reset clears the entry count.
// The receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none

module nearest_landmark_association
  import nla_pkg::*;
#(
  parameter int MAX_LANDMARKS = MAX_LANDMARKS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic        [FUNC_W-1:0]     in_func,
  input  wire logic signed [COORD_BITS-1:0] in_pos_x,
  input  wire logic signed [COORD_BITS-1:0] in_pos_y,
  input  wire logic        [ID_W-1:0]       in_landmark_id,
  output      logic                         out_valid,
  output      logic signed [OUT_W-1:0]      out_matched_id
);

  cmd_t    cmd;
  status_t status;

  nla_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .func   (in_func),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  nla_datapath #(
    .MAX_LANDMARKS (MAX_LANDMARKS),
    .COORD_BITS    (COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_landmark_id (in_landmark_id),
    .status         (status),
    .out_valid      (out_valid),
    .out_matched_id (out_matched_id)
  );

endmodule

`default_nettype wire

[hdl/nla_ctrl.sv]
// Controller state machine for the nearest landmark association block.
// Decodes requests and sequences the table scan; depends on nla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nla_ctrl
  import nla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [FUNC_W-1:0] func,
  input  wire status_t           status,
  output      logic              busy,
  output      cmd_t              cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && func == FUNC_ASSOC) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.init   = start && func == FUNC_ASSOC;
        cmd.clear  = start && func == FUNC_CLEAR;
        cmd.append = start && func == FUNC_APPEND;
      end
      ST_SCAN: begin
        cmd.issue = !status.scan_done;
      end
      ST_DRAIN: begin
        cmd.report = !status.pipe_busy;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/nla_datapath.sv]
// Datapath for the nearest landmark association block: landmark memory,
// distance pipeline and running minimum; depends on nla_pkg and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_landmark_association_macros.svh"

module nla_datapath
  import nla_pkg::*;
#(
  parameter int MAX_LANDMARKS = MAX_LANDMARKS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cmd_t                         cmd,
  input  wire logic signed [COORD_BITS-1:0] in_pos_x,
  input  wire logic signed [COORD_BITS-1:0] in_pos_y,
  input  wire logic        [ID_W-1:0]       in_landmark_id,
  output      status_t                      status,
  output      logic                         out_valid,
  output      logic signed [OUT_W-1:0]      out_matched_id
);

  localparam int AW     = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int CW     = $clog2(MAX_LANDMARKS + 1);
  localparam int WORD_W = 2 * COORD_BITS + ID_W;
  localparam int DW     = COORD_BITS + 1;
  localparam int CMP_W  = (DW > LIM_W) ? DW : LIM_W;
  localparam int MAG_W  = (DW < LIM_W) ? DW : LIM_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LANDMARKS);

  logic [WORD_W-1:0] mem [MAX_LANDMARKS];

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         rd_idx_r;
  logic [COORD_BITS-1:0] obs_x_r;
  logic [COORD_BITS-1:0] obs_y_r;

  logic [WORD_W-1:0] rd_data_r;
  logic              v0_r;

  logic [MAG_W-1:0] magx_r;
  logic [MAG_W-1:0] magy_r;
  logic             far1_r;
  logic [ID_W-1:0]  id1_r;
  logic             v1_r;

  logic [SQ_W-1:0] sqx_r;
  logic [SQ_W-1:0] sqy_r;
  logic            far2_r;
  logic [ID_W-1:0] id2_r;
  logic            v2_r;

  logic [BEST_W-1:0] best_r;
  logic [OUT_W-1:0]  match_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_id_r;

  logic [COORD_BITS-1:0] lx;
  logic [COORD_BITS-1:0] ly;
  logic [ID_W-1:0]       lid;
  logic [DW-1:0]         diff_x;
  logic [DW-1:0]         diff_y;
  logic [DW-1:0]         abs_x;
  logic [DW-1:0]         abs_y;
  logic                  far;
  logic [BEST_W-1:0]     dist_sq;

  always_ff @(posedge clk) begin
    if (cmd.append && count_r < MAX_CNT) begin
      mem[count_r[AW-1:0]] <= {in_landmark_id, in_pos_y, in_pos_x};
    end
    rd_data_r <= mem[rd_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.append && count_r < MAX_CNT) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.init) begin
        rd_idx_r <= '0;
      end else if (cmd.issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      obs_x_r <= in_pos_x;
      obs_y_r <= in_pos_y;
    end
  end

  assign lx  = rd_data_r[COORD_BITS-1:0];
  assign ly  = rd_data_r[2*COORD_BITS-1:COORD_BITS];
  assign lid = rd_data_r[WORD_W-1:2*COORD_BITS];

  assign diff_x = {obs_x_r[COORD_BITS-1], obs_x_r} - {lx[COORD_BITS-1], lx};
  assign diff_y = {obs_y_r[COORD_BITS-1], obs_y_r} - {ly[COORD_BITS-1], ly};
  assign abs_x  = diff_x[DW-1] ? (~diff_x + 1'b1) : diff_x;
  assign abs_y  = diff_y[DW-1] ? (~diff_y + 1'b1) : diff_y;
  assign far    = (CMP_W'(abs_x) >= CMP_W'(CUTOFF_RAW)) ||
                  (CMP_W'(abs_y) >= CMP_W'(CUTOFF_RAW));

  assign dist_sq = BEST_W'(sqx_r) + BEST_W'(sqy_r);

  always_ff @(posedge clk) begin
    magx_r <= abs_x[MAG_W-1:0];
    magy_r <= abs_y[MAG_W-1:0];
    far1_r <= far;
    id1_r  <= lid;
    sqx_r  <= magx_r * magx_r;
    sqy_r  <= magy_r * magy_r;
    far2_r <= far1_r;
    id2_r  <= id1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= cmd.issue;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      best_r  <= CUTOFF_SQ;
      match_r <= NO_MATCH;
    end else if (v2_r && !far2_r && dist_sq < best_r) begin
      best_r  <= dist_sq;
      match_r <= {1'b0, id2_r};
    end
    if (cmd.report) begin
      out_id_r <= match_r;
    end
  end

  assign status.scan_done = (rd_idx_r == count_r);
  assign status.pipe_busy = v0_r || v1_r || v2_r;
  assign out_valid        = out_valid_r;
  assign out_matched_id   = out_id_r;

  `NLA_ASSERT_ALWAYS(a_count_bound, count_r <= MAX_CNT, "Entry count exceeds the table depth.")
  `NLA_ASSERT_NEXT(a_pipe_flow, v1_r, v2_r, "A scanned entry was lost in the distance pipeline.")
  `NLA_ASSERT_ALWAYS(a_report_drained, !cmd.report || !(v0_r || v1_r || v2_r),
                     "A result was reported while distances were still in flight.")

endmodule

`default_nettype wire
